@@ hw/rtl/kphd_pkg.sv @@
// -----------------------------------------------------------------------------
// kphd_pkg
// Shared constants, transaction types and register indexes for the key press
// and hold detector.
// -----------------------------------------------------------------------------
`default_nettype none

package kphd_pkg;

   // Sizing
   localparam int KEY_COUNT     = 5;
   localparam int COUNT_BITS    = 8;
   localparam int CFG_BITS      = 8;
   localparam int CMP_BITS      = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
   localparam int CSR_DATA_BITS = (KEY_COUNT > CFG_BITS) ? KEY_COUNT : CFG_BITS;
   localparam int CSR_IDX_BITS  = 2;

   // Key positions
   localparam int KEY_UP    = 0;
   localparam int KEY_DOWN  = 1;
   localparam int KEY_POWER = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Reset values of the registers
   localparam logic [KEY_COUNT-1:0] ENABLE_RESET    = '1;
   localparam logic [CFG_BITS-1:0]  THRESHOLD_RESET = CFG_BITS'(10);
   localparam logic [CFG_BITS-1:0]  LIMIT_RESET     = CFG_BITS'(25);

   // Transaction kinds
   localparam logic KIND_SCAN  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_ENABLE     = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAST_THRESHOLD = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_POWER_LIMIT    = CSR_IDX_BITS'(2);

   typedef struct packed {
      logic                 kind;
      logic [KEY_COUNT-1:0] key_levels;
      logic                 fast_allowed;
      logic                 power_is_on;
      logic [KEY_COUNT-1:0] clear_mask;
   } req_type;

   typedef struct packed {
      logic [KEY_COUNT-1:0] pending_keys;
      logic                 fast_mode;
      logic                 power_off_request;
      logic                 wake_request;
   } rsp_type;

   // Broadcast from the top level to every lane
   typedef struct packed {
      logic                scan;
      logic                clear;
      logic                fast_ok;
      logic [CFG_BITS-1:0] threshold;
   } lane_ctl_type;

   // What each lane reports to the merge stage
   typedef struct packed {
      logic                  pend_in;
      logic [COUNT_BITS-1:0] cnt_in;
      logic                  fast_set;
      logic                  fast_clr;
      logic                  released;
   } lane_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/kphd_lane.sv @@
// -----------------------------------------------------------------------------
// kphd_lane
// One key: pending and lock bits, saturating hold counter and repeat detect.
// -----------------------------------------------------------------------------
`default_nettype none

module kphd_lane
   import kphd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lane_ctl_type  ctl,
   input  wire logic          level,
   input  wire logic          enable,
   input  wire logic          clear_bit,
   input  wire logic          repeat_key,
   output lane_stat_type      stat
);

   logic                  pend_ff, pend_in;
   logic                  lock_ff, lock_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] cnt_inc;

   assign cnt_inc = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + COUNT_BITS'(1);

   always_comb begin
      pend_in       = pend_ff;
      lock_in       = lock_ff;
      cnt_in        = cnt_ff;
      stat.fast_set = 1'b0;
      stat.fast_clr = 1'b0;
      stat.released = 1'b0;
      if (ctl.scan && enable) begin
         if (level) begin
            if (!pend_ff && !lock_ff) begin
               pend_in = 1'b1;
               lock_in = 1'b1;
               cnt_in  = '0;
            end else begin
               cnt_in = cnt_inc;
               // auto-repeat once held long enough
               if (repeat_key && ctl.fast_ok &&
                   (CMP_BITS'(cnt_inc) >= CMP_BITS'(ctl.threshold))) begin
                  pend_in       = 1'b1;
                  stat.fast_set = 1'b1;
               end
            end
         end else begin
            lock_in       = 1'b0;
            cnt_in        = '0;
            stat.fast_clr = repeat_key;
            stat.released = 1'b1;
         end
      end else if (ctl.clear && clear_bit) begin
         pend_in = 1'b0;
      end
      stat.pend_in = pend_in;
      stat.cnt_in  = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         lock_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         lock_ff <= lock_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/kphd_merge.sv @@
// -----------------------------------------------------------------------------
// kphd_merge
// Combine lane reports: fast mode, power release memory and power-off request.
// -----------------------------------------------------------------------------
`default_nettype none

module kphd_merge
   import kphd_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lane_ctl_type                  ctl,
   input  wire lane_stat_type [KEY_COUNT-1:0] stat,
   input  wire logic [KEY_COUNT-1:0]          key_levels,
   input  wire logic                          power_is_on,
   input  wire logic [CFG_BITS-1:0]           power_limit,
   output rsp_type                            result
);

   logic                 fast_ff, fast_in;
   logic                 prs_ff, prs_in;
   logic                 poff;
   logic [KEY_COUNT-1:0] pend_vec;

   // Keys are taken in order, so the highest lane with an event decides
   always_comb begin
      fast_in = fast_ff;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (stat[i].fast_set) begin
            fast_in = 1'b1;
         end else if (stat[i].fast_clr) begin
            fast_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         pend_vec[i] = stat[i].pend_in;
      end
   end

   if (KEY_POWER < KEY_COUNT) begin : g_power
      assign prs_in = prs_ff | (stat[KEY_POWER].released & power_is_on);
      assign poff   = ctl.scan && prs_in && key_levels[KEY_POWER] &&
                      (CMP_BITS'(stat[KEY_POWER].cnt_in) > CMP_BITS'(power_limit));
   end else begin : g_no_power
      assign prs_in = prs_ff;
      assign poff   = 1'b0;
   end

   assign result.pending_keys      = pend_vec;
   assign result.fast_mode         = fast_in;
   assign result.power_off_request = poff;
   assign result.wake_request      = |pend_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= 1'b0;
         prs_ff  <= 1'b0;
      end else begin
         fast_ff <= fast_in;
         prs_ff  <= prs_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/key_press_hold_detector.sv @@
// -----------------------------------------------------------------------------
// key_press_hold_detector
// Keypad scanner with press latching, hold counting, up/down auto-repeat and a
// long-press power-off request. One lane per key, merged into one result.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | req_payload  (req_type)
//   rsp     | out       | rsp_valid/stall    | rsp_payload  (rsp_type)
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One transaction per cycle while req_stall is low; each result is registered.
// All lanes update their key in the accept cycle, the merge stage closes it.
// A two-entry output stage (result register plus skid) decouples rsp_stall:
// req_stall rises only once both entries are full, and is a register output.
// Reset is synchronous; all state and valid registers take their reset values;
// the output data registers are not reset. csr writes are always taken.
// -----------------------------------------------------------------------------
`default_nettype none

module key_press_hold_detector
   import kphd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [KEY_COUNT-1:0] enable_ff;
   logic [CFG_BITS-1:0]  threshold_ff;
   logic [CFG_BITS-1:0]  limit_ff;

   logic                          accept;
   lane_ctl_type                  ctl;
   lane_stat_type [KEY_COUNT-1:0] stat;
   rsp_type                       result;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   // Configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= ENABLE_RESET;
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_ENABLE:     enable_ff    <= KEY_COUNT'(csr_data);
            CSR_FAST_THRESHOLD: threshold_ff <= CFG_BITS'(csr_data);
            CSR_POWER_LIMIT:    limit_ff     <= CFG_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   // Lanes
   assign accept        = req_valid && !req_stall;
   assign ctl.scan      = accept && (req_payload.kind == KIND_SCAN);
   assign ctl.clear     = accept && (req_payload.kind == KIND_CLEAR);
   assign ctl.fast_ok   = req_payload.fast_allowed;
   assign ctl.threshold = threshold_ff;

   for (genvar i = 0; i < KEY_COUNT; i++) begin : g_lane
      kphd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .level      (req_payload.key_levels[i]),
         .enable     (enable_ff[i]),
         .clear_bit  (req_payload.clear_mask[i]),
         .repeat_key (1'((i == KEY_UP) || (i == KEY_DOWN))),
         .stat       (stat[i])
      );
   end

   kphd_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .stat        (stat),
      .key_levels  (req_payload.key_levels),
      .power_is_on (req_payload.power_is_on),
      .power_limit (limit_ff),
      .result      (result)
   );

   // Output stage: result register with a skid entry behind it
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (accept) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // advance the waiting transaction
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall   = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/kphd_checker.sv @@
// -----------------------------------------------------------------------------
// kphd_checker
// Port-level checks on the key press and hold detector, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module kphd_checker
   import kphd_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire rsp_type                  rsp_payload
);

   // An accepted transaction always leaves a result on the output
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted transaction produced no result");

   // Input back-pressure only starts behind a stalled, full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall && req_valid))
      else $error("req_stall raised without a stalled result");

   // Wake follows the pending keys it reports
   a_wake_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.wake_request == (rsp_payload.pending_keys != '0)))
      else $error("wake_request disagrees with pending_keys");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // Nothing is presented straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind key_press_hold_detector kphd_checker u_kphd_checker (.*);

`default_nettype wire
